// File: hw/rtl/fmag_pkg.sv
package fmag_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int LOG_MAX     = $clog2(MAX_POINTS);
    localparam int ADDR_W      = LOG_MAX;
    localparam int SAMPLE_BITS = 16;
    localparam int DATA_W      = 32;
    localparam int SIZE_W      = 4;
    localparam int BIN_W       = 10;
    localparam int MAG_W       = 15;
    localparam int LOG_W       = $clog2(LOG_MAX + 1);
    localparam int TWI_W       = LOG_MAX - 1;
    localparam int QS_W        = 31;
    localparam int QTAB_N      = MAX_POINTS / 4 + 1;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BF_RD,
        ST_BF_CALC,
        ST_WLO,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_WHI,
        ST_RV_RD,
        ST_RV_W0,
        ST_RV_W1,
        ST_Q0,
        ST_Q1,
        ST_Q2,
        ST_SQRT
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] s;
    } t_tw;

    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_sqrt_rsp;

    // sin(2*pi*k/MAX_POINTS) in Q30 by an eleven-term Taylor series
    function automatic logic [QS_W-1:0] quarter_sin(int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (PI_Q30 * 64'd2 * 64'(k)) / MAX_POINTS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
        return QS_W'(sum);
    endfunction

    function automatic logic [QTAB_N*QS_W-1:0] build_qsin();
        logic [QTAB_N*QS_W-1:0] r;
        r = '0;
        for (int k = 0; k < QTAB_N; k++) r[k*QS_W +: QS_W] = quarter_sin(k);
        return r;
    endfunction

    localparam logic [QTAB_N*QS_W-1:0] QSIN_TAB = build_qsin();

    function automatic t_tw tw_of(logic [TWI_W-1:0] j);
        logic [TWI_W:0] si;
        logic [TWI_W:0] ci;
        logic           neg;
        t_tw            r;
        if ({1'b0, j} <= (TWI_W+1)'(MAX_POINTS / 4)) begin
            si  = {1'b0, j};
            ci  = (TWI_W+1)'(MAX_POINTS / 4) - {1'b0, j};
            neg = 1'b0;
        end else begin
            si  = (TWI_W+1)'(MAX_POINTS / 2) - {1'b0, j};
            ci  = {1'b0, j} - (TWI_W+1)'(MAX_POINTS / 4);
            neg = 1'b1;
        end
        r.s = $signed({{(DATA_W-QS_W){1'b0}}, QSIN_TAB[si*QS_W +: QS_W]});
        r.c = neg ? -$signed({{(DATA_W-QS_W){1'b0}}, QSIN_TAB[ci*QS_W +: QS_W]})
                  :  $signed({{(DATA_W-QS_W){1'b0}}, QSIN_TAB[ci*QS_W +: QS_W]});
        return r;
    endfunction

endpackage

// File: hw/rtl/fmag_ram.sv
module fmag_ram #(
    parameter int AW = 10,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// File: hw/rtl/fmag_isqrt.sv
module fmag_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fmag_pkg::t_sqrt_req i_req,
    output fmag_pkg::t_sqrt_rsp o_rsp
);

    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    // one result bit per cycle, 32 steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_v    <= i_req.value;
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[31:0];

endmodule

// File: hw/rtl/fft_magnitude_spectrum_core.sv
// Magnitude spectrum core: radix-2 decimation-in-frequency FFT over one frame.
//
// Command channel: an item transfers at a rising edge with start high and busy
// low. i_func 0 loads the next real sample of the frame; the last
// sample of a frame starts the in-place transform and the bit-reversal pass,
// during which busy stays high. i_func 1 reads one bin magnitude.
// Result channel: o_res_valid is high for exactly one cycle with o_magnitude
// and o_ready_res; the receiver cannot stall it, so no result is held back.
// Read path: when no frame is ready or the bin is at or above N/4 the result
// follows in the next cycle; otherwise it passes through a memory read, two
// squares on the shared multiplier and the square-root unit before it shows.
// Transform: a butterfly reads its pair, forms sum and difference, then writes
// the low and high results; where a twiddle multiply follows, four products
// go through the one 32x32 multiplier before the high write. The reorder pass
// reads each index with its bit-reverse and swaps the pair where needed; the
// butterfly sequencer and the single data-memory write port set the frame time.
// Configuration: i_cfg_valid/o_cfg_ready writes size_log2 and restarts the
// frame; ready only while idle. Reset clears control state, not the memory.
module fft_magnitude_spectrum_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic signed [fmag_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [fmag_pkg::BIN_W-1:0]          i_bin,
    output logic                                o_res_valid,
    output logic [fmag_pkg::MAG_W-1:0]          o_magnitude,
    output logic                                o_ready_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fmag_pkg::SIZE_W-1:0]         i_cfg_data
);

    localparam int AW = fmag_pkg::ADDR_W;
    localparam int DW = fmag_pkg::DATA_W;

    fmag_pkg::t_state r_state, n_state;

    logic [fmag_pkg::SIZE_W-1:0] r_size;
    logic [AW:0]                 r_ld;
    logic                        r_ready;
    logic [fmag_pkg::LOG_W-1:0]  r_k;
    logic [AW-2:0]               r_t;
    logic [AW-1:0]               r_idx;
    logic signed [DW-1:0]        r_sr, r_si, r_hr, r_hi, r_tre, r_c, r_s;
    logic signed [63:0]          r_prod, r_acc;
    logic                        r_res_valid, r_res_ready;
    logic [fmag_pkg::MAG_W-1:0]  r_mag;

    logic [fmag_pkg::LOG_W-1:0]  eff_e;
    logic [AW:0]                 n_pts;
    logic                        accept;
    logic                        q_fast;
    logic [AW:0]                 ld_eff;
    logic [AW-1:0]               tx, kmask, bf_lo, bf_hi, rev_full, rev;
    logic [fmag_pkg::TWI_W-1:0]  tw_j;
    fmag_pkg::t_tw               tw;
    logic                        twid, t_last;
    logic signed [DW:0]          s_r, s_i, d_r, d_i;
    logic signed [DW-1:0]        mul_a, mul_b;
    logic signed [63:0]          mul_p;
    logic                        we;
    logic [AW-1:0]               waddr, raddr_a, raddr_b;
    logic [2*DW-1:0]             wdata, rdata_a, rdata_b;
    fmag_pkg::t_sqrt_req         sq_req;
    fmag_pkg::t_sqrt_rsp         sq_rsp;
    logic [32:0]                 mag_sum, mag_sh;

    function automatic logic signed [DW-1:0] sat_add(logic signed [DW:0] v);
        if (v > $signed({2'b00, {(DW-1){1'b1}}}))       return {1'b0, {(DW-1){1'b1}}};
        else if (v < $signed({2'b11, {(DW-1){1'b0}}}))  return {1'b1, {(DW-1){1'b0}}};
        else                                           return v[DW-1:0];
    endfunction

    // round half up out of Q30, then saturate
    function automatic logic signed [DW-1:0] sat_rnd(logic signed [64:0] v);
        logic signed [64:0] w;
        logic signed [34:0] q;
        w = v + 65'sd536870912;
        q = 35'(w >>> 30);
        if (q > $signed({4'b0000, {(DW-1){1'b1}}}))      return {1'b0, {(DW-1){1'b1}}};
        else if (q < $signed({4'b1111, {(DW-1){1'b0}}})) return {1'b1, {(DW-1){1'b0}}};
        else                                            return q[DW-1:0];
    endfunction

    // out-of-range sizes clamp to one .. LOG_MAX
    always_comb begin
        if (r_size == '0)                                   eff_e = fmag_pkg::LOG_W'(1);
        else if (r_size > fmag_pkg::SIZE_W'(fmag_pkg::LOG_MAX))
            eff_e = fmag_pkg::LOG_W'(fmag_pkg::LOG_MAX);
        else                                                eff_e = fmag_pkg::LOG_W'(r_size);
    end

    assign n_pts  = (AW+1)'(1) << eff_e;
    assign accept = start && !busy;
    assign q_fast = !r_ready || ({1'b0, i_bin} >= (fmag_pkg::BIN_W+1)'(n_pts >> 2));
    assign ld_eff = (r_ready || (r_ld >= n_pts)) ? '0 : r_ld;

    // butterfly addressing: insert a zero at bit k of the butterfly index
    assign tx     = AW'(r_t);
    assign kmask  = (AW'(1) << r_k) - AW'(1);
    assign bf_lo  = ((tx >> r_k) << (r_k + 1)) | (tx & kmask);
    assign bf_hi  = bf_lo | (AW'(1) << r_k);
    assign tw_j   = fmag_pkg::TWI_W'((tx & kmask) << (fmag_pkg::LOG_MAX - 1 - int'(r_k)));
    assign tw     = fmag_pkg::tw_of(tw_j);
    assign twid   = ((tx & kmask) != '0) && (r_k != '0);
    assign t_last = (tx == AW'((n_pts >> 1) - (AW+1)'(1)));

    always_comb begin
        for (int b = 0; b < AW; b++) rev_full[b] = r_idx[AW-1-b];
    end
    assign rev = rev_full >> (fmag_pkg::LOG_W'(fmag_pkg::LOG_MAX) - eff_e);

    assign s_r = $signed(rdata_a[2*DW-1:DW]) + $signed(rdata_b[2*DW-1:DW]);
    assign d_r = $signed(rdata_a[2*DW-1:DW]) - $signed(rdata_b[2*DW-1:DW]);
    assign s_i = $signed(rdata_a[DW-1:0]) + $signed(rdata_b[DW-1:0]);
    assign d_i = $signed(rdata_a[DW-1:0]) - $signed(rdata_b[DW-1:0]);

    // shared multiplier
    always_comb begin
        mul_a = r_hr;
        mul_b = r_c;
        case (r_state)
            fmag_pkg::ST_M1: begin mul_a = r_hi; mul_b = r_s; end
            fmag_pkg::ST_M2: begin mul_a = r_hi; mul_b = r_c; end
            fmag_pkg::ST_M3: begin mul_a = r_hr; mul_b = r_s; end
            fmag_pkg::ST_Q0: begin
                mul_a = $signed(rdata_a[2*DW-1:DW]);
                mul_b = $signed(rdata_a[2*DW-1:DW]);
            end
            fmag_pkg::ST_Q1: begin mul_a = r_hi; mul_b = r_hi; end
            default: ;
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign sq_req.start = (r_state == fmag_pkg::ST_Q2);
    assign sq_req.value = 64'(r_acc) + 64'(r_prod);

    assign mag_sum = 33'(sq_rsp.root) + 33'(n_pts >> 1);
    assign mag_sh  = mag_sum >> eff_e;

    // next state and memory control
    always_comb begin
        n_state = r_state;
        we      = 1'b0;
        waddr   = bf_lo;
        wdata   = {r_sr, r_si};
        raddr_a = bf_lo;
        raddr_b = bf_hi;
        unique case (r_state)
            fmag_pkg::ST_IDLE: begin
                raddr_a = AW'(i_bin);
                if (accept && !i_func) begin
                    we    = 1'b1;
                    waddr = ld_eff[AW-1:0];
                    wdata = {{(DW-fmag_pkg::SAMPLE_BITS){i_sample[fmag_pkg::SAMPLE_BITS-1]}},
                             i_sample, {DW{1'b0}}};
                    if (ld_eff + (AW+1)'(1) == n_pts) n_state = fmag_pkg::ST_BF_RD;
                end else if (accept && i_func && !q_fast) begin
                    n_state = fmag_pkg::ST_Q0;
                end
            end
            fmag_pkg::ST_BF_RD:   n_state = fmag_pkg::ST_BF_CALC;
            fmag_pkg::ST_BF_CALC: n_state = twid ? fmag_pkg::ST_M0 : fmag_pkg::ST_WLO;
            fmag_pkg::ST_WLO: begin
                we      = 1'b1;
                n_state = fmag_pkg::ST_WHI;
            end
            fmag_pkg::ST_M0: begin
                we      = 1'b1;
                n_state = fmag_pkg::ST_M1;
            end
            fmag_pkg::ST_M1: n_state = fmag_pkg::ST_M2;
            fmag_pkg::ST_M2: n_state = fmag_pkg::ST_M3;
            fmag_pkg::ST_M3: n_state = fmag_pkg::ST_M4;
            fmag_pkg::ST_M4: n_state = fmag_pkg::ST_WHI;
            fmag_pkg::ST_WHI: begin
                we    = 1'b1;
                waddr = bf_hi;
                wdata = {r_hr, r_hi};
                if (t_last && r_k == '0) n_state = fmag_pkg::ST_RV_RD;
                else                     n_state = fmag_pkg::ST_BF_RD;
            end
            fmag_pkg::ST_RV_RD: begin
                raddr_a = r_idx;
                raddr_b = rev;
                if (r_idx < rev)                                n_state = fmag_pkg::ST_RV_W0;
                else if ({1'b0, r_idx} == n_pts - (AW+1)'(1))   n_state = fmag_pkg::ST_IDLE;
            end
            fmag_pkg::ST_RV_W0: begin
                we      = 1'b1;
                waddr   = r_idx;
                wdata   = rdata_b;
                n_state = fmag_pkg::ST_RV_W1;
            end
            fmag_pkg::ST_RV_W1: begin
                we      = 1'b1;
                waddr   = rev;
                wdata   = {r_sr, r_si};
                n_state = fmag_pkg::ST_RV_RD;
            end
            fmag_pkg::ST_Q0: n_state = fmag_pkg::ST_Q1;
            fmag_pkg::ST_Q1: n_state = fmag_pkg::ST_Q2;
            fmag_pkg::ST_Q2: n_state = fmag_pkg::ST_SQRT;
            fmag_pkg::ST_SQRT: begin
                if (sq_rsp.done) n_state = fmag_pkg::ST_IDLE;
            end
            default: n_state = fmag_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= fmag_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= fmag_pkg::SIZE_W'(10);
            r_ld        <= '0;
            r_ready     <= 1'b0;
            r_res_valid <= 1'b0;
            r_k         <= '0;
            r_t         <= '0;
            r_idx       <= '0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size  <= i_cfg_data;
                r_ld    <= '0;
                r_ready <= 1'b0;
            end
            unique case (r_state)
                fmag_pkg::ST_IDLE: begin
                    if (accept && !i_func) begin
                        r_ready <= 1'b0;
                        if (ld_eff + (AW+1)'(1) == n_pts) begin
                            r_ld <= '0;
                            r_k  <= eff_e - fmag_pkg::LOG_W'(1);
                            r_t  <= '0;
                        end else begin
                            r_ld <= ld_eff + (AW+1)'(1);
                        end
                    end else if (accept && i_func && q_fast) begin
                        r_res_valid <= 1'b1;
                    end
                end
                fmag_pkg::ST_WHI: begin
                    if (t_last) begin
                        r_t <= '0;
                        if (r_k == '0) r_idx <= '0;
                        else           r_k   <= r_k - fmag_pkg::LOG_W'(1);
                    end else begin
                        r_t <= r_t + (AW-1)'(1);
                    end
                end
                fmag_pkg::ST_RV_RD: begin
                    if (!(r_idx < rev)) begin
                        if ({1'b0, r_idx} == n_pts - (AW+1)'(1)) r_ready <= 1'b1;
                        else                                    r_idx   <= r_idx + AW'(1);
                    end
                end
                fmag_pkg::ST_RV_W1: r_idx <= r_idx + AW'(1);
                fmag_pkg::ST_SQRT: begin
                    if (sq_rsp.done) r_res_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fmag_pkg::ST_IDLE: begin
                r_res_ready <= r_ready;
                r_mag       <= '0;
            end
            fmag_pkg::ST_BF_CALC: begin
                r_sr <= sat_add(s_r);
                r_si <= sat_add(s_i);
                r_hr <= sat_add(d_r);
                r_hi <= sat_add(d_i);
                r_c  <= tw.c;
                r_s  <= tw.s;
            end
            fmag_pkg::ST_M0: r_prod <= mul_p;
            fmag_pkg::ST_M1: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            fmag_pkg::ST_M2: begin
                r_tre  <= sat_rnd(65'(r_acc) + 65'(r_prod));
                r_prod <= mul_p;
            end
            fmag_pkg::ST_M3: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            fmag_pkg::ST_M4: begin
                r_hr <= r_tre;
                r_hi <= sat_rnd(65'(r_acc) - 65'(r_prod));
            end
            fmag_pkg::ST_RV_W0: begin
                r_sr <= $signed(rdata_a[2*DW-1:DW]);
                r_si <= $signed(rdata_a[DW-1:0]);
            end
            fmag_pkg::ST_Q0: begin
                r_prod <= mul_p;
                r_hi   <= $signed(rdata_a[DW-1:0]);
            end
            fmag_pkg::ST_Q1: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            fmag_pkg::ST_SQRT: begin
                r_res_ready <= r_ready;
                r_mag <= (mag_sh > 33'd32767) ? {fmag_pkg::MAG_W{1'b1}}
                                              : mag_sh[fmag_pkg::MAG_W-1:0];
            end
            default: ;
        endcase
    end

    fmag_ram #(
        .AW(AW),
        .DW(2 * DW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr_a(raddr_a),
        .i_raddr_b(raddr_b),
        .o_rdata_a(rdata_a),
        .o_rdata_b(rdata_b)
    );

    fmag_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (sq_req),
        .o_rsp  (sq_rsp)
    );

    // hold off configuration while a transform or a read is under way
    assign busy        = (r_state != fmag_pkg::ST_IDLE);
    assign o_cfg_ready = !busy;
    assign o_res_valid = r_res_valid;
    assign o_magnitude = r_mag;
    assign o_ready_res = r_res_ready;

endmodule

// File: hw/rtl/fmag_checker.sv
module fmag_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                i_func,
    input logic                                o_res_valid,
    input logic [fmag_pkg::MAG_W-1:0]          o_magnitude,
    input logic                                o_ready_res
);

    // a result without a ready frame carries no magnitude
    a_zero_unready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_ready_res |-> o_magnitude == '0)
        else $error("magnitude without ready frame");

    // a result only shows once the sequencer is back at rest
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result while busy");

    // a sample load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_func |=> !o_res_valid)
        else $error("result after load");

    // reset leaves the block idle and silent
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_res_valid)
        else $error("not idle after reset");

endmodule

bind fft_magnitude_spectrum_core fmag_checker u_fmag_checker (.*);
